// ----- src/htdar_pkg.sv -----
// Shared types and constants for the depth-aged hash table unit.
`default_nettype none
package htdar_pkg;

    localparam int KEY_W   = 64;
    localparam int SCORE_W = 21;
    localparam int MOVE_W  = 16;
    localparam int SDEPTH_W = 9;
    localparam int DEPTH_W = 8;
    localparam int GEN_W   = 8;
    localparam int BOUND_W = 2;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'd255;
    localparam logic [BOUND_W-1:0] BOUND_EMPTY = 2'd0;

    typedef enum logic [1:0] {
        MODE_PROBE   = 2'd0,
        MODE_STORE   = 2'd1,
        MODE_ADVANCE = 2'd2,
        MODE_CLEAR   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic signed [SCORE_W-1:0] score;
        logic [MOVE_W-1:0]         move;
        logic [DEPTH_W-1:0]        depth;
        logic [GEN_W-1:0]          gen;
        logic [BOUND_W-1:0]        bound;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic commit;
        logic clear_run;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  out_free;
        logic  clear_last;
    } status_t;

endpackage
`default_nettype wire

// ----- src/htdar_ctrl.sv -----
// Controller state machine: sequences accept, evaluate and clearing sweep.
`default_nettype none
module htdar_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire htdar_pkg::status_t status,
    output htdar_pkg::cmd_t        cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd.capture   = 1'b0;
        cmd.commit    = 1'b0;
        cmd.clear_run = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_run = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = (status.mode == htdar_pkg::MODE_CLEAR) ? S_CLEAR : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/htdar_dp.sv -----
// Datapath: entry memory, generation counter, replace decision and result register.
`default_nettype none
module htdar_dp #(
    parameter int INDEX_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic [1:0]                            mode,
    input  wire logic [htdar_pkg::KEY_W-1:0]           key,
    input  wire logic signed [htdar_pkg::SCORE_W-1:0]  score,
    input  wire logic [htdar_pkg::MOVE_W-1:0]          move_word,
    input  wire logic [htdar_pkg::SDEPTH_W-1:0]        search_depth,
    input  wire logic [htdar_pkg::BOUND_W-1:0]         bound,
    input  wire htdar_pkg::cmd_t                       cmd,
    output htdar_pkg::status_t                         status,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic                                       hit,
    output logic signed [htdar_pkg::SCORE_W-1:0]       hit_score,
    output logic [htdar_pkg::MOVE_W-1:0]               hit_move,
    output logic [htdar_pkg::DEPTH_W-1:0]              hit_depth,
    output logic [htdar_pkg::GEN_W-1:0]                hit_gen,
    output logic [htdar_pkg::BOUND_W-1:0]              hit_bound,
    output logic                                       written
);

    localparam int DEPTH = 1 << INDEX_BITS;

    htdar_pkg::entry_t mem [DEPTH];
    htdar_pkg::entry_t rd_data_reg;

    htdar_pkg::mode_t                        mode_reg;
    logic [htdar_pkg::KEY_W-1:0]             key_reg;
    logic signed [htdar_pkg::SCORE_W-1:0]    score_reg;
    logic [htdar_pkg::MOVE_W-1:0]            move_reg;
    logic [htdar_pkg::SDEPTH_W-1:0]          depth_reg;
    logic [htdar_pkg::BOUND_W-1:0]           bound_reg;

    logic [htdar_pkg::GEN_W-1:0]             gen_reg;
    logic [INDEX_BITS-1:0]                   clr_cnt_reg;
    logic                                    out_valid_reg;

    logic [INDEX_BITS-1:0]                   rd_addr;
    logic [INDEX_BITS-1:0]                   wr_addr;
    htdar_pkg::entry_t                       wr_data;
    htdar_pkg::entry_t                       new_entry;
    logic                                    wr_en;
    logic                                    is_empty;
    logic                                    is_stale;
    logic                                    is_deeper;
    logic                                    replace;
    logic                                    probe_hit;

    assign rd_addr = cmd.capture ? key[INDEX_BITS-1:0] : key_reg[INDEX_BITS-1:0];

    assign is_empty  = (rd_data_reg.bound == htdar_pkg::BOUND_EMPTY);
    assign is_stale  = (rd_data_reg.gen != gen_reg);
    assign is_deeper = (depth_reg >= {1'b0, rd_data_reg.depth});
    assign replace   = is_empty || is_stale || is_deeper;
    assign probe_hit = (rd_data_reg.key == key_reg) && !is_empty;

    always_comb
    begin
        new_entry.key   = key_reg;
        new_entry.score = score_reg;
        new_entry.move  = move_reg;
        new_entry.depth = depth_reg[htdar_pkg::SDEPTH_W-1] ? htdar_pkg::DEPTH_MAX
                                                           : depth_reg[htdar_pkg::DEPTH_W-1:0];
        new_entry.gen   = gen_reg;
        new_entry.bound = bound_reg;
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = key_reg[INDEX_BITS-1:0];
        wr_data = new_entry;
        if (cmd.clear_run)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else if (cmd.commit && (mode_reg == htdar_pkg::MODE_STORE) && replace)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg   <= key;
            score_reg <= score;
            move_reg  <= move_word;
            depth_reg <= search_depth;
            bound_reg <= bound;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= htdar_pkg::MODE_PROBE;
            gen_reg       <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                mode_reg <= htdar_pkg::mode_t'(mode);
            end
            if (cmd.clear_run)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                if (mode_reg == htdar_pkg::MODE_ADVANCE)
                begin
                    gen_reg <= gen_reg + 1'b1;
                end
                else if (mode_reg == htdar_pkg::MODE_CLEAR)
                begin
                    gen_reg <= '0;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit       <= 1'b0;
            hit_score <= '0;
            hit_move  <= '0;
            hit_depth <= '0;
            hit_gen   <= '0;
            hit_bound <= '0;
            written   <= 1'b0;
            unique case (mode_reg)
                htdar_pkg::MODE_PROBE:
                begin
                    if (probe_hit)
                    begin
                        hit       <= 1'b1;
                        hit_score <= rd_data_reg.score;
                        hit_move  <= rd_data_reg.move;
                        hit_depth <= rd_data_reg.depth;
                        hit_gen   <= rd_data_reg.gen;
                        hit_bound <= rd_data_reg.bound;
                    end
                end
                htdar_pkg::MODE_STORE:
                begin
                    written <= replace;
                end
                htdar_pkg::MODE_ADVANCE,
                htdar_pkg::MODE_CLEAR:
                begin
                    written <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid         = out_valid_reg;
    assign status.mode       = mode_reg;
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.clear_last = &clr_cnt_reg;

endmodule
`default_nettype wire

// ----- src/hash_table_depth_aged_replace_unit.sv -----
// Top level: depth-preferred, generation-aged direct-mapped hash table.
// Probe, store and advance each go through accept and memory read, then evaluate and write.
// A new item is accepted only after the previous one has been evaluated; in_ready is low meanwhile.
// Clear returns its result, then sweeps every entry of the memory with in_ready low.
// Reset is asynchronous, active low; it zeroes the generation and starts the same
// clearing sweep of every entry before the first item is accepted.
`default_nettype none
module hash_table_depth_aged_replace_unit #(
    parameter int INDEX_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [1:0]                            mode,
    input  wire logic [htdar_pkg::KEY_W-1:0]           key,
    input  wire logic signed [htdar_pkg::SCORE_W-1:0]  score,
    input  wire logic [htdar_pkg::MOVE_W-1:0]          move_word,
    input  wire logic [htdar_pkg::SDEPTH_W-1:0]        search_depth,
    input  wire logic [htdar_pkg::BOUND_W-1:0]         bound,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic                                       hit,
    output logic signed [htdar_pkg::SCORE_W-1:0]       hit_score,
    output logic [htdar_pkg::MOVE_W-1:0]               hit_move,
    output logic [htdar_pkg::DEPTH_W-1:0]              hit_depth,
    output logic [htdar_pkg::GEN_W-1:0]                hit_gen,
    output logic [htdar_pkg::BOUND_W-1:0]              hit_bound,
    output logic                                       written
);

    htdar_pkg::cmd_t    cmd;
    htdar_pkg::status_t status;

    htdar_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    htdar_dp #(
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (mode),
        .key          (key),
        .score        (score),
        .move_word    (move_word),
        .search_depth (search_depth),
        .bound        (bound),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .hit_score    (hit_score),
        .hit_move     (hit_move),
        .hit_depth    (hit_depth),
        .hit_gen      (hit_gen),
        .hit_bound    (hit_bound),
        .written      (written)
    );

endmodule
`default_nettype wire

// ----- src/htdar_checker.sv -----
// Port-level checker for the hash table unit and its bind.
`default_nettype none
module htdar_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_ready,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic       hit,
    input  wire logic [1:0] hit_bound,
    input  wire logic       written
);

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on consecutive cycles");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    a_hit_xor_written: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && written))
        else $error("result reports both hit and written");

    a_hit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hit == (hit_bound != htdar_pkg::BOUND_EMPTY)))
        else $error("hit flag disagrees with reported bound");

endmodule

bind hash_table_depth_aged_replace_unit htdar_checker u_htdar_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .hit_bound (hit_bound),
    .written   (written)
);
`default_nettype wire
